FILE: src/lbsc_pkg.sv
// ----------------------------------------------------------------------------
// lbsc_pkg
// Shared widths, codes and controller-to-datapath command type for the
// line-block signal controller.
// ----------------------------------------------------------------------------
package lbsc_pkg;

  // Line geometry
  localparam int MAX_SECTIONS = 16;
  localparam int SECT_W       = MAX_SECTIONS;   // width of section / signal masks
  localparam int IDX_W        = 5;              // section_index width
  localparam int LEN_W        = 5;              // line_length width
  localparam int MIN_LENGTH   = 2;

  // Request types
  localparam logic [1:0] REQ_BLOCK   = 2'd0;
  localparam logic [1:0] REQ_OCCUPY  = 2'd1;
  localparam logic [1:0] REQ_FREE    = 2'd2;
  localparam logic [1:0] REQ_RELEASE = 2'd3;

  // Block modes (own and opposite direction)
  localparam logic [1:0] MODE_UNDEF = 2'd0;
  localparam logic [1:0] MODE_READY = 2'd1;
  localparam logic [1:0] MODE_OCC   = 2'd2;

  // Head indicator codes
  localparam logic [2:0] HEAD_OWN_READY = 3'd0;
  localparam logic [2:0] HEAD_OWN_OCC   = 3'd1;
  localparam logic [2:0] HEAD_OPP_READY = 3'd2;
  localparam logic [2:0] HEAD_OPP_OCC   = 3'd3;
  localparam logic [2:0] HEAD_NONE      = 3'd4;

  // Configuration register index
  localparam logic REG_LINE_LENGTH = 1'b0;
  localparam logic [LEN_W-1:0] LINE_LENGTH_RST = LEN_W'(MIN_LENGTH);

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the accepted request
    logic exec;   // apply the request and load the result register
  } lbsc_cmd_t;

endpackage

FILE: src/lbsc_ctrl.sv
// ----------------------------------------------------------------------------
// lbsc_ctrl
// Sequencer: captures a request, then applies it once the result register
// is free, and drives both handshakes.
// ----------------------------------------------------------------------------
module lbsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output lbsc_pkg::lbsc_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  state_t state_r;
  logic   in_stall_r;
  logic   out_valid_r;

  // command decode
  always_comb begin
    cmd.load = (state_r == ST_IDLE) && in_valid;
    cmd.exec = (state_r == ST_CALC) && (!out_valid_r || !out_stall);
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r    <= ST_CALC;
            in_stall_r <= 1'b1;
          end
        end
        ST_CALC: begin
          if (cmd.exec) begin
            state_r    <= ST_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_stall_r <= 1'b0;
        end
      endcase

      // result slot: filled by exec, emptied when taken
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

FILE: src/lbsc_dp.sv
// ----------------------------------------------------------------------------
// lbsc_dp
// Datapath: request capture with line masks, block state registers and
// the result register.
// ----------------------------------------------------------------------------
module lbsc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lbsc_pkg::lbsc_cmd_t           cmd,
  input  logic [lbsc_pkg::LEN_W-1:0]    line_length,
  input  logic [1:0]                    in_req_type,
  input  logic [lbsc_pkg::IDX_W-1:0]    in_section_index,
  input  logic                          in_opposite_present,
  input  logic [1:0]                    in_opposite_state,
  input  logic [lbsc_pkg::SECT_W-1:0]   in_route_mask,
  output logic                          out_accepted,
  output logic [1:0]                    out_block_mode,
  output logic                          out_cleared,
  output logic [lbsc_pkg::SECT_W-1:0]   out_aspect_mask,
  output logic [2:0]                    out_head_indicator
);

  localparam int SW = lbsc_pkg::SECT_W;

  // captured request
  logic [1:0]              req_r;
  logic                    idx_zero_r;
  logic                    opp_here_r;
  logic [1:0]              opp_mode_r;
  logic [SW-1:0]           routes_r;
  logic [SW-1:0]           line_mask_r;   // sections on the line
  logic [SW-1:0]           idx_bit_r;     // one-hot section, zero when off line
  logic [SW-1:0]           below_mask_r;  // sections before the index

  // block state
  logic [1:0]    mode_r,  mode_nxt;
  logic          clr_r,   clr_nxt;
  logic [SW-1:0] occ_r,   occ_nxt;
  logic [SW-1:0] asp_r,   asp_nxt;

  // result register
  logic          res_acc_r;
  logic [1:0]    res_mode_r;
  logic          res_clr_r;
  logic [SW-1:0] res_asp_r;
  logic [2:0]    res_head_r;

  // effective length and masks for the capture stage
  logic [lbsc_pkg::LEN_W-1:0] n_eff;
  logic [SW-1:0]              line_mask_c;
  logic [SW-1:0]              below_mask_c;
  logic                       idx_on_c;

  always_comb begin
    if (line_length < lbsc_pkg::LEN_W'(lbsc_pkg::MIN_LENGTH)) begin
      n_eff = lbsc_pkg::LEN_W'(lbsc_pkg::MIN_LENGTH);
    end else if (line_length > lbsc_pkg::LEN_W'(lbsc_pkg::MAX_SECTIONS)) begin
      n_eff = lbsc_pkg::LEN_W'(lbsc_pkg::MAX_SECTIONS);
    end else begin
      n_eff = line_length;
    end
    for (int i = 0; i < SW; i++) begin
      line_mask_c[i]  = lbsc_pkg::LEN_W'(i) < n_eff;
      below_mask_c[i] = lbsc_pkg::IDX_W'(i) < in_section_index;
    end
    idx_on_c = in_section_index < n_eff;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r        <= in_req_type;
      idx_zero_r   <= (in_section_index == '0);
      opp_here_r   <= in_opposite_present;
      opp_mode_r   <= in_opposite_state;
      routes_r     <= in_route_mask;
      line_mask_r  <= line_mask_c;
      below_mask_r <= below_mask_c;
      idx_bit_r    <= idx_on_c ? (SW'(1) << in_section_index[$clog2(SW)-1:0]) : '0;
    end
  end

  // event evaluation
  logic [SW-1:0] hi_mask;    // sections 1 and up
  logic [SW-1:0] sig_mask;   // signals 0 .. n-2
  logic [SW-1:0] sig_bit;    // signal behind the indexed section
  logic          grant;
  logic          any_occ;
  logic          occ_before;
  logic [2:0]    head;

  always_comb begin
    hi_mask  = line_mask_r & ~SW'(1);
    sig_mask = line_mask_r >> 1;
    sig_bit  = idx_zero_r ? '0 : (idx_bit_r >> 1);

    grant = (req_r == lbsc_pkg::REQ_BLOCK) && idx_zero_r && opp_here_r &&
            (opp_mode_r != lbsc_pkg::MODE_READY) &&
            (opp_mode_r != lbsc_pkg::MODE_OCC) &&
            ((routes_r & hi_mask) == '0) &&
            !((mode_r == lbsc_pkg::MODE_UNDEF) && ((occ_r & hi_mask) != '0));

    mode_nxt   = mode_r;
    clr_nxt    = clr_r;
    occ_nxt    = occ_r;
    asp_nxt    = asp_r;
    any_occ    = 1'b0;
    occ_before = 1'b0;

    case (req_r)
      lbsc_pkg::REQ_BLOCK: begin
        if (grant) begin
          if (mode_r == lbsc_pkg::MODE_UNDEF) begin
            mode_nxt = lbsc_pkg::MODE_READY;
          end
          // proceed for every signal whose guarded section is free
          asp_nxt = asp_r | (~(occ_r >> 1) & sig_mask);
          clr_nxt = 1'b1;
        end
      end
      lbsc_pkg::REQ_OCCUPY: begin
        occ_nxt = occ_r | idx_bit_r;
        if (mode_r != lbsc_pkg::MODE_UNDEF) begin
          if (mode_r == lbsc_pkg::MODE_READY) begin
            mode_nxt = lbsc_pkg::MODE_OCC;
          end
          if (idx_zero_r) begin
            clr_nxt = 1'b0;   // idx 0 is always on the line
          end
          asp_nxt = asp_r & ~sig_bit;
        end
      end
      lbsc_pkg::REQ_FREE: begin
        occ_nxt = occ_r & ~idx_bit_r;
        if (mode_r != lbsc_pkg::MODE_UNDEF) begin
          any_occ    = (occ_nxt & line_mask_r) != '0;
          occ_before = (occ_nxt & line_mask_r & below_mask_r) != '0;
          if (!any_occ) begin
            mode_nxt = clr_r ? lbsc_pkg::MODE_READY : lbsc_pkg::MODE_UNDEF;
          end
          if (occ_before || clr_r) begin
            asp_nxt = asp_r | sig_bit;
          end
        end
      end
      default: begin
        // release
        if (mode_r == lbsc_pkg::MODE_READY) begin
          mode_nxt = lbsc_pkg::MODE_UNDEF;
          asp_nxt  = asp_r & ~sig_mask;
        end
      end
    endcase

    // head indicator from the new mode
    if (mode_nxt == lbsc_pkg::MODE_READY) begin
      head = lbsc_pkg::HEAD_OWN_READY;
    end else if (mode_nxt == lbsc_pkg::MODE_OCC) begin
      head = lbsc_pkg::HEAD_OWN_OCC;
    end else if (opp_here_r && (opp_mode_r == lbsc_pkg::MODE_READY)) begin
      head = lbsc_pkg::HEAD_OPP_READY;
    end else if (opp_here_r && (opp_mode_r == lbsc_pkg::MODE_OCC)) begin
      head = lbsc_pkg::HEAD_OPP_OCC;
    end else begin
      head = lbsc_pkg::HEAD_NONE;
    end
  end

  // block state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lbsc_pkg::MODE_UNDEF;
      clr_r  <= 1'b0;
      occ_r  <= '0;
      asp_r  <= '0;
    end else if (cmd.exec) begin
      mode_r <= mode_nxt;
      clr_r  <= clr_nxt;
      occ_r  <= occ_nxt;
      asp_r  <= asp_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_acc_r  <= grant;
      res_mode_r <= mode_nxt;
      res_clr_r  <= clr_nxt;
      res_asp_r  <= asp_nxt;
      res_head_r <= head;
    end
  end

  assign out_accepted       = res_acc_r;
  assign out_block_mode     = res_mode_r;
  assign out_cleared        = res_clr_r;
  assign out_aspect_mask    = res_asp_r;
  assign out_head_indicator = res_head_r;

endmodule

FILE: src/line_block_signal_controller_core.sv
// ----------------------------------------------------------------------------
// line_block_signal_controller_core
// A request is captured when accepted, then applied and its result loaded
// into the result register once that register is free (capture/apply
// sequencer). A new request is not taken until the last one is applied;
// it is taken while the previous result waits in its register.
// Reset (synchronous, active low): mode undefined, cleared 0, all sections
// free, all signals stop, line_length 2.
// ----------------------------------------------------------------------------
module line_block_signal_controller_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [lbsc_pkg::IDX_W-1:0]    in_section_index,
  input  logic                          in_opposite_present,
  input  logic [1:0]                    in_opposite_state,
  input  logic [lbsc_pkg::SECT_W-1:0]   in_route_mask,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic [1:0]                    out_block_mode,
  output logic                          out_cleared,
  output logic [lbsc_pkg::SECT_W-1:0]   out_aspect_mask,
  output logic [2:0]                    out_head_indicator,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  lbsc_pkg::lbsc_cmd_t        cmd;
  logic [lbsc_pkg::LEN_W-1:0] line_length_r;
  logic                       cfg_hit;

  // register decode: word index is paddr[2]
  assign cfg_hit    = (cfg_paddr[2] == lbsc_pkg::REG_LINE_LENGTH);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= lbsc_pkg::LINE_LENGTH_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      line_length_r <= cfg_pwdata[lbsc_pkg::LEN_W-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? {{(32-lbsc_pkg::LEN_W){1'b0}}, line_length_r} : '0;

  lbsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lbsc_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .line_length         (line_length_r),
    .in_req_type         (in_req_type),
    .in_section_index    (in_section_index),
    .in_opposite_present (in_opposite_present),
    .in_opposite_state   (in_opposite_state),
    .in_route_mask       (in_route_mask),
    .out_accepted        (out_accepted),
    .out_block_mode      (out_block_mode),
    .out_cleared         (out_cleared),
    .out_aspect_mask     (out_aspect_mask),
    .out_head_indicator  (out_head_indicator)
  );

endmodule
